// ===== rtl/core/dacks_pkg.sv =====
// Shared types, constants and helper functions for the DHCP ACK option snooper.
// No dependencies; every other file of the block imports this package.
package dacks_pkg;

    // Width used for position and packet-end arithmetic (covers 14 + 65535 + 256)
    localparam int CMP_W = 18;

    // Frame offsets, assuming 14-byte Ethernet and 20-byte IPv4 headers
    localparam logic [CMP_W-1:0] POS_DEST_END   = CMP_W'(6);
    localparam logic [CMP_W-1:0] POS_LEN_HI     = CMP_W'(16);
    localparam logic [CMP_W-1:0] POS_LEN_LO     = CMP_W'(17);
    localparam logic [CMP_W-1:0] POS_YIADDR_LO  = CMP_W'(58);
    localparam logic [CMP_W-1:0] POS_YIADDR_HI  = CMP_W'(61);
    localparam logic [CMP_W-1:0] POS_CHADDR_LO  = CMP_W'(70);
    localparam logic [CMP_W-1:0] POS_CHADDR_HI  = CMP_W'(75);
    localparam logic [CMP_W-1:0] POS_COOKIE_LO  = CMP_W'(278);
    localparam logic [CMP_W-1:0] POS_COOKIE_HI  = CMP_W'(281);
    localparam logic [CMP_W-1:0] POS_OPT_START  = CMP_W'(282);
    localparam logic [CMP_W-1:0] ETH_HDR_BYTES  = CMP_W'(14);

    // Option codes and markers
    localparam logic [7:0] OPT_PAD       = 8'h00;
    localparam logic [7:0] OPT_MASK      = 8'h01;
    localparam logic [7:0] OPT_LEASE     = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_END       = 8'hff;
    localparam logic [7:0] MSG_ACK       = 8'd5;
    localparam logic [7:0] MASK_OPT_LEN  = 8'd4;
    localparam logic [7:0] LEASE_OPT_LEN = 8'd4;
    localparam logic [5:0] PREFIX_FULL   = 6'd32;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_BAD_COOKIE = 3'd3;
    localparam logic [2:0] ST_ZERO_MASK = 3'd4;

    // Option walker phase, one-hot
    typedef enum logic [3:0] {
        PH_CODE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        is_ack;
        logic [7:0]  msg_type;
        logic [31:0] offered_ip;
        logic [47:0] client_mac;
        logic [5:0]  prefix_len;
        logic [31:0] lease_seconds;
        logic        lease_present;
        logic        dest_broadcast;
    } t_result;

    // Magic cookie byte; index 0 is the first byte on the wire
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'd99;
            2'd1:    v = 8'd130;
            2'd2:    v = 8'd83;
            default: v = 8'd99;
        endcase
        return v;
    endfunction

    // 32 minus trailing zeros of the mask; 32 for an all-zero word
    function automatic logic [5:0] prefix_of(input logic [31:0] m);
        logic [5:0] n;
        n = PREFIX_FULL;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) begin
                n = 6'(32 - i);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/dhcp_ack_option_snooper.sv =====
// Top level of the DHCP ACK option snooper: input register, frame parser and
// result register. Depends on dacks_pkg, dacks_in_stage, dacks_parser, dacks_out_stage.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+--------------------------------------------
//   in       | i_valid / o_ready  | i_data_byte, i_last_byte
//   out      | o_valid / i_ready  | o_status, o_is_ack, o_msg_type, o_offered_ip,
//            |                    | o_client_mac, o_prefix_len, o_lease_seconds,
//            |                    | o_lease_present, o_dest_broadcast
//
// One byte per clock sustained while the result register can take a last byte. A byte goes
// from the input register through the parser; o_valid rises when the result of the
// last byte of a frame is loaded into the result register.
// Reset is synchronous and clears the frame state; no clearing pass.
// A stall on the output holds only a last byte; other bytes keep flowing.
module dhcp_ack_option_snooper
    import dacks_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_is_ack,
    output logic [7:0]  o_msg_type,
    output logic [31:0] o_offered_ip,
    output logic [47:0] o_client_mac,
    output logic [5:0]  o_prefix_len,
    output logic [31:0] o_lease_seconds,
    output logic        o_lease_present,
    output logic        o_dest_broadcast
);

    t_in_item in_item;
    t_in_item stg_item;
    logic     stg_valid;
    logic     take;
    logic     out_free;
    logic     res_load;
    t_result  res_next;
    t_result  res_q;

    assign in_item.data_byte = i_data_byte;
    assign in_item.last_byte = i_last_byte;

    dacks_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_take  (take),
        .o_ready (o_ready),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    dacks_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stg_valid),
        .i_item     (stg_item),
        .i_out_free (out_free),
        .o_take     (take),
        .o_res_load (res_load),
        .o_result   (res_next)
    );

    dacks_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_load),
        .i_result (res_next),
        .i_ready  (i_ready),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (res_q)
    );

    assign o_status         = res_q.status;
    assign o_is_ack         = res_q.is_ack;
    assign o_msg_type       = res_q.msg_type;
    assign o_offered_ip     = res_q.offered_ip;
    assign o_client_mac     = res_q.client_mac;
    assign o_prefix_len     = res_q.prefix_len;
    assign o_lease_seconds  = res_q.lease_seconds;
    assign o_lease_present  = res_q.lease_present;
    assign o_dest_broadcast = res_q.dest_broadcast;

endmodule

// ===== rtl/core/dacks_in_stage.sv =====
// Input register of the DHCP ACK option snooper: holds one byte transaction.
// Depends on dacks_pkg.
module dacks_in_stage
    import dacks_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_take,
    output logic     o_ready,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/core/dacks_parser.sv =====
// Frame parser of the DHCP ACK option snooper: header capture, option walk
// and status evaluation, one byte per cycle while the result register can take a last byte. Depends on dacks_pkg.
module dacks_parser
    import dacks_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_out_free,
    output logic     o_take,
    output logic     o_res_load,
    output t_result  o_result
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] r_pos,      n_pos;
    logic [15:0]      r_iplen,    n_iplen;
    logic [31:0]      r_offer,    n_offer;
    logic [47:0]      r_hw,       n_hw;
    logic             r_bcast,    n_bcast;
    logic             r_cookie,   n_cookie;
    t_phase           r_phase,    n_phase;
    logic [7:0]       r_code,     n_code;
    logic [7:0]       r_rem,      n_rem;
    logic [31:0]      r_data,     n_data;
    logic [7:0]       r_type,     n_type;
    logic [5:0]       r_prefix,   n_prefix;
    logic             r_mask_err, n_mask_err;
    logic             r_mask_seen, n_mask_seen;
    logic [31:0]      r_lease,    n_lease;
    logic             r_lease_ok, n_lease_ok;

    logic             step;
    logic [7:0]       b;
    logic [CMP_W-1:0] p;
    logic [CMP_W-1:0] pkt_end;
    logic [CMP_W-1:0] flen;
    logic [7:0]       eff_code;
    logic [7:0]       rem_dec;
    logic [31:0]      data_sh;
    logic [2:0]       st;

    // A last byte needs room in the result register
    assign step       = i_valid && (!i_item.last_byte || i_out_free);
    assign o_take     = step;
    assign o_res_load = step && i_item.last_byte;
    assign b          = i_item.data_byte;
    assign p          = CMP_W'(r_pos);
    assign pkt_end    = ETH_HDR_BYTES + CMP_W'(r_iplen);

    always_comb begin
        n_pos       = r_pos;
        n_iplen     = r_iplen;
        n_offer     = r_offer;
        n_hw        = r_hw;
        n_bcast     = r_bcast;
        n_cookie    = r_cookie;
        n_phase     = r_phase;
        n_code      = r_code;
        n_rem       = r_rem;
        n_data      = r_data;
        n_type      = r_type;
        n_prefix    = r_prefix;
        n_mask_err  = r_mask_err;
        n_mask_seen = r_mask_seen;
        n_lease     = r_lease;
        n_lease_ok  = r_lease_ok;
        eff_code    = r_code;
        rem_dec     = r_rem - 8'd1;
        data_sh     = {r_data[23:0], b};

        // Bytes past the size limit are dropped
        if (r_pos < POS_MAX) begin
            n_pos = r_pos + POS_W'(1);
            if (p < POS_DEST_END && b != OPT_END) begin
                n_bcast = 1'b0;
            end
            if (p == POS_LEN_HI) begin
                n_iplen = {b, 8'h00};
            end
            if (p == POS_LEN_LO) begin
                n_iplen = {r_iplen[15:8], b};
            end
            if (p >= POS_YIADDR_LO && p <= POS_YIADDR_HI) begin
                n_offer = {r_offer[23:0], b};
            end
            if (p >= POS_CHADDR_LO && p <= POS_CHADDR_HI) begin
                n_hw = {r_hw[39:0], b};
            end
            if (p >= POS_COOKIE_LO && p <= POS_COOKIE_HI
                    && b != magic_byte(p[1:0] - 2'd2)) begin
                n_cookie = 1'b0;
            end

            if (p >= POS_OPT_START && p < pkt_end && r_phase != PH_DONE) begin
                case (r_phase)
                    PH_CODE: begin
                        if (b == OPT_END) begin
                            n_phase = PH_DONE;
                        end else if (b != OPT_PAD) begin
                            n_code  = b;
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (p + CMP_W'(1) + CMP_W'(b) > pkt_end) begin
                            // Truncated option: stop without using it
                            n_phase = PH_DONE;
                        end else if (r_code == OPT_MASK && b != MASK_OPT_LEN
                                     && !r_mask_seen) begin
                            n_mask_err = 1'b1;
                            n_phase    = PH_DONE;
                        end else begin
                            if (r_code == OPT_MASK && b != MASK_OPT_LEN) begin
                                eff_code = OPT_PAD;
                            end
                            if (r_code == OPT_LEASE && b != LEASE_OPT_LEN) begin
                                eff_code = OPT_PAD;
                            end
                            if (r_code == OPT_MSG_TYPE && b == 8'd0) begin
                                eff_code = OPT_PAD;
                            end
                            n_code  = eff_code;
                            n_rem   = b;
                            n_data  = 32'd0;
                            n_phase = (b != 8'd0) ? PH_DATA : PH_CODE;
                        end
                    end
                    PH_DATA: begin
                        n_data = data_sh;
                        if (r_code == OPT_MSG_TYPE) begin
                            n_type   = b;
                            eff_code = OPT_PAD;
                        end
                        n_code = eff_code;
                        n_rem  = rem_dec;
                        if (rem_dec == 8'd0) begin
                            n_phase = PH_CODE;
                            if (eff_code == OPT_MASK) begin
                                if (data_sh == 32'd0) begin
                                    n_mask_err = 1'b1;
                                    n_phase    = PH_DONE;
                                end else begin
                                    n_prefix    = prefix_of(data_sh);
                                    n_mask_seen = 1'b1;
                                end
                            end else if (eff_code == OPT_LEASE) begin
                                n_lease    = data_sh;
                                n_lease_ok = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    // Status on the updated state; lowest error code wins
    assign flen = CMP_W'(n_pos);

    always_comb begin
        if (flen < POS_OPT_START) begin
            st = ST_SHORT;
        end else if (CMP_W'(n_iplen) > flen - ETH_HDR_BYTES) begin
            st = ST_BAD_LEN;
        end else if (!n_cookie) begin
            st = ST_BAD_COOKIE;
        end else if (n_mask_err) begin
            st = ST_ZERO_MASK;
        end else begin
            st = ST_OK;
        end
    end

    always_comb begin
        o_result.status         = st;
        o_result.is_ack         = (st == ST_OK) && (n_type == MSG_ACK) && (n_offer != 32'd0);
        o_result.msg_type       = n_type;
        o_result.offered_ip     = n_offer;
        o_result.client_mac     = n_hw;
        o_result.prefix_len     = n_prefix;
        o_result.lease_seconds  = n_lease;
        o_result.lease_present  = n_lease_ok;
        o_result.dest_broadcast = n_bcast;
    end

    // Clear all frame state on reset and after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_load) begin
            r_pos       <= '0;
            r_iplen     <= '0;
            r_offer     <= '0;
            r_hw        <= '0;
            r_bcast     <= 1'b1;
            r_cookie    <= 1'b1;
            r_phase     <= PH_CODE;
            r_code      <= '0;
            r_rem       <= '0;
            r_data      <= '0;
            r_type      <= '0;
            r_prefix    <= PREFIX_FULL;
            r_mask_err  <= 1'b0;
            r_mask_seen <= 1'b0;
            r_lease     <= '0;
            r_lease_ok  <= 1'b0;
        end else if (step) begin
            r_pos       <= n_pos;
            r_iplen     <= n_iplen;
            r_offer     <= n_offer;
            r_hw        <= n_hw;
            r_bcast     <= n_bcast;
            r_cookie    <= n_cookie;
            r_phase     <= n_phase;
            r_code      <= n_code;
            r_rem       <= n_rem;
            r_data      <= n_data;
            r_type      <= n_type;
            r_prefix    <= n_prefix;
            r_mask_err  <= n_mask_err;
            r_mask_seen <= n_mask_seen;
            r_lease     <= n_lease;
            r_lease_ok  <= n_lease_ok;
        end
    end

endmodule

// ===== rtl/core/dacks_out_stage.sv =====
// Result register of the DHCP ACK option snooper: holds one result transaction
// until the consumer takes it. Depends on dacks_pkg.
module dacks_out_stage
    import dacks_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/core/dacks_checker.sv =====
// Port-level checks for the DHCP ACK option snooper, bound to the top level.
// Depends on dacks_pkg and dhcp_ack_option_snooper.
module dacks_checker
    import dacks_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic        o_is_ack,
    input logic [7:0]  o_msg_type,
    input logic [31:0] o_offered_ip,
    input logic [47:0] o_client_mac,
    input logic [5:0]  o_prefix_len,
    input logic [31:0] o_lease_seconds,
    input logic        o_lease_present
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_client_mac))
        else $error("result changed while stalled");

    // No result straight out of reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_ack_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_ack |-> o_status == ST_OK && o_msg_type == MSG_ACK
                                && o_offered_ip != 32'd0)
        else $error("ack flag without ok status, ack type and address");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_ZERO_MASK && o_prefix_len != 6'd0
                    && o_prefix_len <= PREFIX_FULL)
        else $error("status or prefix length out of range");

    // A lease value without its flag must be zero
    a_lease_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_lease_present |-> o_lease_seconds == 32'd0)
        else $error("lease value without lease option");

endmodule

bind dhcp_ack_option_snooper dacks_checker u_dacks_checker (.*);

// ===== tb/sv/dhcp_ack_option_snooper_tb.sv =====
// Testbench for dhcp_ack_option_snooper: builds Ethernet/IPv4/DHCP frames, sends them one byte
// per transaction and checks every frame result against a behavioral model kept here.
// Depends on dacks_pkg and the RTL of the snooper; needs no files or arguments.
module dhcp_ack_option_snooper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dacks_pkg::*;

    localparam int          HDR_ETH     = 14;
    localparam int          AT_IPLEN    = 16;
    localparam int          AT_YIADDR   = 58;
    localparam int          AT_CHADDR   = 70;
    localparam int          AT_COOKIE   = 278;
    localparam int          AT_OPTIONS  = 282;
    localparam int          FRAME_CAP   = 2048;
    localparam int          IDLE_PCT    = 34;
    localparam logic [31:0] COOKIE_WORD = {8'd99, 8'd130, 8'd83, 8'd99};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic        o_is_ack;
    logic [7:0]  o_msg_type;
    logic [31:0] o_offered_ip;
    logic [47:0] o_client_mac;
    logic [5:0]  o_prefix_len;
    logic [31:0] o_lease_seconds;
    logic        o_lease_present;
    logic        o_dest_broadcast;

    // Frame under construction and results still owed by the block
    logic [7:0]  frame_q[$];
    t_result     pending_results[$];
    t_result     seen_result;
    t_result     due_result;
    int          mismatch_count = 0;
    int          results_checked = 0;
    logic        no_idle = 1'b0;

    // Parser state of the local model
    int          frame_pos;
    int          ip_len;
    logic [31:0] yiaddr;
    logic [47:0] chaddr;
    logic        dst_all_ones;
    logic        cookie_good;
    t_phase      walk;
    logic [7:0]  cur_code;
    int          bytes_left;
    logic [31:0] opt_word;
    logic [7:0]  seen_type;
    logic [5:0]  prefix;
    logic        mask_err;
    logic [31:0] lease_word;
    logic        lease_seen;
    logic        mask_valid;

    dhcp_ack_option_snooper u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_is_ack         (o_is_ack),
        .o_msg_type       (o_msg_type),
        .o_offered_ip     (o_offered_ip),
        .o_client_mac     (o_client_mac),
        .o_prefix_len     (o_prefix_len),
        .o_lease_seconds  (o_lease_seconds),
        .o_lease_present  (o_lease_present),
        .o_dest_broadcast (o_dest_broadcast)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // ---------------------------------------------------------------- model

    task automatic clear_frame_state();
        frame_pos    = 0;
        ip_len       = 0;
        yiaddr       = '0;
        chaddr       = '0;
        dst_all_ones = 1'b1;
        cookie_good  = 1'b1;
        walk         = PH_CODE;
        cur_code     = OPT_PAD;
        bytes_left   = 0;
        opt_word     = '0;
        seen_type    = '0;
        prefix       = PREFIX_FULL;
        mask_err     = 1'b0;
        lease_word   = '0;
        lease_seen   = 1'b0;
        mask_valid   = 1'b0;
    endtask

    function automatic logic [5:0] mask_to_prefix(input logic [31:0] m);
        int tz = 0;
        while (tz < 32 && m[tz] == 1'b0) tz++;
        return 6'(32 - tz);
    endfunction

    task automatic walk_option(input int p, input logic [7:0] b);
        int pkt_end;
        pkt_end = HDR_ETH + ip_len;
        case (walk)
            PH_CODE: begin
                if (b == OPT_END) begin
                    walk = PH_DONE;
                end else if (b != OPT_PAD) begin
                    cur_code = b;
                    walk = PH_LEN;
                end
            end
            PH_LEN: begin
                // drop an option whose data would run past the packet end
                if (p + 1 + int'(b) > pkt_end) begin
                    walk = PH_DONE;
                end else if (cur_code == OPT_MASK && b != MASK_OPT_LEN && !mask_valid) begin
                    mask_err = 1'b1;
                    walk = PH_DONE;
                end else begin
                    if (cur_code == OPT_MASK && b != MASK_OPT_LEN) cur_code = OPT_PAD;
                    if (cur_code == OPT_LEASE && b != LEASE_OPT_LEN) cur_code = OPT_PAD;
                    if (cur_code == OPT_MSG_TYPE && b == 8'd0) cur_code = OPT_PAD;
                    bytes_left = int'(b);
                    opt_word = '0;
                    walk = (b != 8'd0) ? PH_DATA : PH_CODE;
                end
            end
            PH_DATA: begin
                opt_word = {opt_word[23:0], b};
                if (cur_code == OPT_MSG_TYPE) begin
                    seen_type = b;
                    cur_code = OPT_PAD;
                end
                bytes_left--;
                if (bytes_left == 0) begin
                    walk = PH_CODE;
                    if (cur_code == OPT_MASK) begin
                        if (opt_word == '0) begin
                            mask_err = 1'b1;
                            walk = PH_DONE;
                        end else begin
                            prefix = mask_to_prefix(opt_word);
                            mask_valid = 1'b1;
                        end
                    end else if (cur_code == OPT_LEASE) begin
                        lease_word = opt_word;
                        lease_seen = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Advance the model by one accepted byte; queue the frame result on the last one
    task automatic snoop_byte(input logic [7:0] b, input logic last);
        t_result r;
        int      p;
        if (frame_pos < FRAME_CAP) begin
            p = frame_pos;
            if (p < 6 && b != 8'hff) dst_all_ones = 1'b0;
            if (p == AT_IPLEN) ip_len = int'(b) << 8;
            if (p == AT_IPLEN + 1) ip_len = ip_len | int'(b);
            if (p >= AT_YIADDR && p < AT_YIADDR + 4) yiaddr = {yiaddr[23:0], b};
            if (p >= AT_CHADDR && p < AT_CHADDR + 6) chaddr = {chaddr[39:0], b};
            if (p >= AT_COOKIE && p < AT_OPTIONS &&
                b != COOKIE_WORD[31 - 8 * (p - AT_COOKIE) -: 8]) cookie_good = 1'b0;
            if (p >= AT_OPTIONS && p < HDR_ETH + ip_len && walk != PH_DONE)
                walk_option(p, b);
            frame_pos++;
        end
        if (last) begin
            if (frame_pos < AT_OPTIONS)                 r.status = ST_SHORT;
            else if (ip_len > frame_pos - HDR_ETH)      r.status = ST_BAD_LEN;
            else if (!cookie_good)                      r.status = ST_BAD_COOKIE;
            else if (mask_err)                          r.status = ST_ZERO_MASK;
            else                                        r.status = ST_OK;
            r.is_ack         = (r.status == ST_OK && seen_type == MSG_ACK && yiaddr != '0);
            r.msg_type       = seen_type;
            r.offered_ip     = yiaddr;
            r.client_mac     = chaddr;
            r.prefix_len     = prefix;
            r.lease_seconds  = lease_word;
            r.lease_present  = lease_seen;
            r.dest_broadcast = dst_all_ones;
            pending_results.push_back(r);
            clear_frame_state();
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] result %0d: %s got 0x%0h, wanted 0x%0h",
                 $realtime, results_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_result.status         = o_status;
            seen_result.is_ack         = o_is_ack;
            seen_result.msg_type       = o_msg_type;
            seen_result.offered_ip     = o_offered_ip;
            seen_result.client_mac     = o_client_mac;
            seen_result.prefix_len     = o_prefix_len;
            seen_result.lease_seconds  = o_lease_seconds;
            seen_result.lease_present  = o_lease_present;
            seen_result.dest_broadcast = o_dest_broadcast;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no frame outstanding", 64'd1, 64'd0);
            end else begin
                due_result = pending_results.pop_front();
                check_field("status", seen_result.status, due_result.status);
                check_field("is_ack", seen_result.is_ack, due_result.is_ack);
                check_field("msg_type", seen_result.msg_type, due_result.msg_type);
                check_field("offered_ip", seen_result.offered_ip, due_result.offered_ip);
                check_field("client_mac", seen_result.client_mac, due_result.client_mac);
                check_field("prefix_len", seen_result.prefix_len, due_result.prefix_len);
                check_field("lease_seconds", seen_result.lease_seconds,
                            due_result.lease_seconds);
                check_field("lease_present", seen_result.lease_present,
                            due_result.lease_present);
                check_field("dest_broadcast", seen_result.dest_broadcast,
                            due_result.dest_broadcast);
            end
            results_checked++;
        end
    end

    // ---------------------------------------------------------------- driving

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        // hold the transaction until the block takes it
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        snoop_byte(b, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // ---------------------------------------------------------------- frame building

    // Fill headers up to the first option byte; IP length is set later
    task automatic begin_dhcp(input logic bcast, input logic [31:0] yi, input logic [47:0] mac);
        logic [7:0] b;
        frame_q.delete();
        for (int p = 0; p < AT_OPTIONS; p++) begin
            b = 8'($urandom);
            if (p < 6) begin
                if (bcast)                  b = 8'hff;
                else if (p == 5)            b = 8'($urandom_range(254));
                else if ($urandom_range(1)) b = 8'hff;
            end else if (p == 12) begin
                b = 8'h08;
            end else if (p == 13) begin
                b = 8'h00;
            end else if (p == 14) begin
                b = 8'h45;
            end else if (p >= AT_YIADDR && p < AT_YIADDR + 4) begin
                b = yi[31 - 8 * (p - AT_YIADDR) -: 8];
            end else if (p >= AT_CHADDR && p < AT_CHADDR + 6) begin
                b = mac[47 - 8 * (p - AT_CHADDR) -: 8];
            end else if (p >= AT_COOKIE) begin
                b = COOKIE_WORD[31 - 8 * (p - AT_COOKIE) -: 8];
            end
            frame_q.push_back(b);
        end
    endtask

    // Data of up to four bytes comes from val, big-endian; longer data is random
    task automatic add_opt(input logic [7:0] code, input int len, input logic [31:0] val);
        frame_q.push_back(code);
        frame_q.push_back(8'(len));
        for (int i = 0; i < len; i++) begin
            if (len <= 4) frame_q.push_back(val[8 * (len - 1 - i) +: 8]);
            else          frame_q.push_back(8'($urandom));
        end
    endtask

    task automatic set_ip_len(input int n);
        frame_q[AT_IPLEN]     = 8'(n >> 8);
        frame_q[AT_IPLEN + 1] = 8'(n);
    endtask

    task automatic close_exact();
        set_ip_len(frame_q.size() - HDR_ETH);
    endtask

    function automatic logic [31:0] random_mask();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 32'h0;
        if (k < 3)  return $urandom;
        return 32'hffff_ffff << $urandom_range(31);
    endfunction

    task automatic add_random_options(input int n);
        int sel;
        int wrong;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(19);
            if (sel < 2) begin
                frame_q.push_back(OPT_PAD);
            end else if (sel < 5) begin
                add_opt(OPT_MSG_TYPE, 1, ($urandom_range(3) == 0) ? $urandom : MSG_ACK);
            end else if (sel == 5) begin
                add_opt(OPT_MSG_TYPE, $urandom_range(3), $urandom);
            end else if (sel < 9) begin
                add_opt(OPT_LEASE, 4, $urandom);
            end else if (sel == 9) begin
                add_opt(OPT_LEASE, $urandom_range(6), $urandom);
            end else if (sel < 13) begin
                add_opt(OPT_MASK, 4, random_mask());
            end else if (sel == 13) begin
                wrong = $urandom_range(5);
                if (wrong >= 4) wrong++;
                add_opt(OPT_MASK, wrong, $urandom);
            end else begin
                add_opt(8'($urandom_range(2, 254)), $urandom_range(12), $urandom);
            end
        end
        if ($urandom_range(99) < 85) frame_q.push_back(OPT_END);
        repeat ($urandom_range(8)) frame_q.push_back(8'($urandom));
    endtask

    task automatic build_random_dhcp();
        int mode;
        begin_dhcp($urandom_range(1), ($urandom_range(3) == 0) ? 32'h0 : $urandom,
                   48'({$urandom, $urandom}));
        add_random_options($urandom_range(1, 8));
        mode = $urandom_range(19);
        if (mode < 14)      close_exact();
        else if (mode < 17) set_ip_len($urandom_range(AT_OPTIONS, frame_q.size()) - HDR_ETH);
        else if (mode < 19) set_ip_len(frame_q.size() - HDR_ETH + $urandom_range(1, 64));
        else                set_ip_len(65535);
    endtask

    task automatic fill_random(input int len);
        frame_q.delete();
        repeat (len) frame_q.push_back(8'($urandom));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_ack_frame();
        begin_dhcp(1'b1, 32'hc0a8_0164, 48'h0011_2233_4455);
        add_opt(OPT_MSG_TYPE, 1, MSG_ACK);
        add_opt(OPT_LEASE, 4, 32'd86400);
        add_opt(OPT_MASK, 4, 32'hffff_ff00);
        frame_q.push_back(OPT_END);
        close_exact();
        send_frame();
        // destination one bit short of broadcast, request instead of ack
        begin_dhcp(1'b1, 32'h0a00_0002, 48'hfeed_0000_beef);
        frame_q[5] = 8'hfe;
        add_opt(OPT_MSG_TYPE, 1, 32'd3);
        frame_q.push_back(OPT_END);
        close_exact();
        send_frame();
    endtask

    task automatic test_field_extremes();
        begin_dhcp(1'b1, 32'hffff_ffff, 48'hffff_ffff_ffff);
        add_opt(OPT_MSG_TYPE, 1, 32'd255);
        add_opt(OPT_LEASE, 4, 32'hffff_ffff);
        add_opt(OPT_MASK, 4, 32'hffff_ffff);
        frame_q.push_back(OPT_END);
        close_exact();
        send_frame();
        // ack type but no offered address, shortest nonzero prefix
        begin_dhcp(1'b0, 32'h0, 48'h0);
        for (int p = 0; p < 6; p++) frame_q[p] = 8'h00;
        add_opt(OPT_MSG_TYPE, 1, MSG_ACK);
        add_opt(OPT_LEASE, 4, 32'h0);
        add_opt(OPT_MASK, 4, 32'h8000_0000);
        frame_q.push_back(OPT_END);
        close_exact();
        send_frame();
    endtask

    task automatic test_short_frames();
        fill_random(1);
        send_frame();
        begin_dhcp(1'b1, 32'h0102_0304, 48'h0a0b_0c0d_0e0f);
        void'(frame_q.pop_back());
        set_ip_len(AT_OPTIONS - 1 - HDR_ETH);
        send_frame();
        // exactly the header, no options at all
        begin_dhcp(1'b1, 32'h0102_0304, 48'h0a0b_0c0d_0e0f);
        close_exact();
        send_frame();
    endtask

    task automatic test_length_and_cookie();
        begin_dhcp(1'b1, 32'h0a01_0101, 48'h1234_5678_9abc);
        frame_q.push_back(OPT_END);
        set_ip_len(frame_q.size() - HDR_ETH + 1);
        send_frame();
        for (int k = 0; k < 4; k++) begin
            begin_dhcp(1'b1, 32'h0a01_0101, 48'h1234_5678_9abc);
            add_opt(OPT_MSG_TYPE, 1, MSG_ACK);
            frame_q.push_back(OPT_END);
            close_exact();
            frame_q[AT_COOKIE + k] = frame_q[AT_COOKIE + k] ^ 8'h40;
            send_frame();
        end
        // several errors at once: the lowest code must win
        begin_dhcp(1'b0, 32'h0a01_0102, 48'h1);
        add_opt(OPT_MASK, 4, 32'h0);
        frame_q.push_back(OPT_END);
        set_ip_len(frame_q.size() - HDR_ETH + 5);
        frame_q[AT_COOKIE] = 8'h00;
        send_frame();
        begin_dhcp(1'b0, 32'h0a01_0102, 48'h1);
        add_opt(OPT_MASK, 4, 32'h0);
        frame_q.push_back(OPT_END);
        close_exact();
        frame_q[AT_COOKIE + 3] = 8'h00;
        send_frame();
    endtask

    task automatic test_mask_cases();
        begin_dhcp(1'b1, 32'hac10_0005, 48'h2);
        add_opt(OPT_MSG_TYPE, 1, MSG_ACK);
        add_opt(OPT_MASK, 4, 32'h0);
        add_opt(OPT_LEASE, 4, 32'd60);
        frame_q.push_back(OPT_END);
        close_exact();
        send_frame();
        // wrong length before any valid mask
        begin_dhcp(1'b1, 32'hac10_0005, 48'h3);
        add_opt(OPT_MASK, 3, 32'hffffff);
        frame_q.push_back(OPT_END);
        close_exact();
        send_frame();
        // wrong length after a valid mask is skipped and the walk goes on
        begin_dhcp(1'b1, 32'hac10_0005, 48'h4);
        add_opt(OPT_MASK, 4, 32'hffff_0000);
        add_opt(OPT_MASK, 6, 32'h0);
        add_opt(OPT_MSG_TYPE, 1, MSG_ACK);
        frame_q.push_back(OPT_END);
        close_exact();
        send_frame();
        // last valid mask wins, including a non-contiguous one
        begin_dhcp(1'b1, 32'hac10_0005, 48'h5);
        add_opt(OPT_MASK, 4, 32'hff00_0000);
        add_opt(OPT_MASK, 4, 32'hffff_fffc);
        add_opt(OPT_MASK, 4, 32'h00ff_0f00);
        frame_q.push_back(OPT_END);
        close_exact();
        send_frame();
    endtask

    task automatic test_truncated_option();
        // lease ends on the last byte of the packet: keep it
        begin_dhcp(1'b1, 32'hc0a8_0a0a, 48'h6);
        add_opt(OPT_MSG_TYPE, 1, MSG_ACK);
        add_opt(OPT_LEASE, 4, 32'h1234_5678);
        close_exact();
        send_frame();
        // lease runs one byte past the packet end: drop it, trailer is ignored
        begin_dhcp(1'b1, 32'hc0a8_0a0a, 48'h7);
        add_opt(OPT_MSG_TYPE, 1, MSG_ACK);
        add_opt(OPT_LEASE, 4, 32'h1234_5678);
        set_ip_len(frame_q.size() - HDR_ETH - 1);
        add_opt(OPT_MSG_TYPE, 1, 32'd2);
        send_frame();
    endtask

    task automatic test_ignored_options();
        begin_dhcp(1'b1, 32'hc0a8_0b01, 48'h8);
        frame_q.push_back(OPT_PAD);
        add_opt(OPT_MSG_TYPE, 1, 32'd3);
        add_opt(OPT_MSG_TYPE, 0, 32'h0);
        add_opt(OPT_LEASE, 3, 32'h00ab_cdef);
        add_opt(OPT_LEASE, 5, 32'h0);
        frame_q.push_back(OPT_PAD);
        frame_q.push_back(OPT_END);
        add_opt(OPT_MSG_TYPE, 1, MSG_ACK);
        add_opt(OPT_LEASE, 4, 32'd99);
        close_exact();
        send_frame();
        // longer message type: only its first data byte counts
        begin_dhcp(1'b1, 32'hc0a8_0b01, 48'h9);
        add_opt(OPT_MSG_TYPE, 2, 32'h0507);
        frame_q.push_back(OPT_END);
        close_exact();
        send_frame();
    endtask

    task automatic test_oversize();
        begin_dhcp(1'b1, 32'h0a0a_0a0a, 48'ha);
        add_opt(OPT_MSG_TYPE, 1, MSG_ACK);
        frame_q.push_back(OPT_END);
        close_exact();
        while (frame_q.size() < FRAME_CAP + 52) frame_q.push_back(8'($urandom));
        send_frame();
        // lease ends on the last counted byte; one longer IP length is a bad length
        for (int extra = 0; extra < 2; extra++) begin
            begin_dhcp(1'b1, 32'h0a0a_0a0b, 48'hb);
            add_opt(OPT_MSG_TYPE, 1, MSG_ACK);
            while (frame_q.size() < FRAME_CAP - 6) frame_q.push_back(OPT_PAD);
            add_opt(OPT_LEASE, 4, 32'hcafe_f00d);
            set_ip_len(FRAME_CAP - HDR_ETH + extra);
            while (frame_q.size() < FRAME_CAP + 52) frame_q.push_back(8'($urandom));
            send_frame();
        end
    endtask

    task automatic test_random_frames(input int n);
        int kind;
        int idx;
        for (int k = 0; k < n; k++) begin
            no_idle = (k >= n / 3 && k < n / 2);
            kind = $urandom_range(99);
            if (kind < 70) begin
                build_random_dhcp();
            end else if (kind < 80) begin
                fill_random($urandom_range(1, AT_OPTIONS - 1));
            end else if (kind < 90) begin
                build_random_dhcp();
                idx = $urandom_range(frame_q.size() - 1);
                frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
            end else begin
                fill_random($urandom_range(AT_OPTIONS, 400));
            end
            send_frame();
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data_byte <= 8'h00;
        i_last_byte <= 1'b0;
        clear_frame_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ack_frame();
        test_field_extremes();
        test_short_frames();
        test_length_and_cookie();
        test_mask_cases();
        test_truncated_option();
        test_ignored_options();
        test_oversize();
        test_random_frames(60);

        i_valid <= 1'b0;
        for (int w = 0; w < 1000 && pending_results.size() != 0; w++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never produced", pending_results.size(), 64'd0);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #1_500_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dacks_pkg.sv
rtl/core/dacks_in_stage.sv
rtl/core/dacks_parser.sv
rtl/core/dacks_out_stage.sv
rtl/core/dhcp_ack_option_snooper.sv
rtl/core/dacks_checker.sv
tb/sv/dhcp_ack_option_snooper_tb.sv
